// File: rtl/dht_pkg.sv
`timescale 1ns / 1ps
package dht_pkg;

    localparam int DEF_TABLE_SLOTS = 1021;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_FOUND    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [31:0] value;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_value;
        logic [9:0]  entry_count;
    } t_out;

    typedef struct packed {
        logic        active;
        logic [31:0] key;
        logic [31:0] value;
    } t_slot;

endpackage

// File: rtl/dht_hash.sv
`timescale 1ns / 1ps
module dht_hash #(
    parameter int TABLE_SLOTS = dht_pkg::DEF_TABLE_SLOTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [31:0]                    i_key,
    output logic                           o_done,
    output logic [$clog2(TABLE_SLOTS)-1:0] o_first,
    output logic [$clog2(TABLE_SLOTS)-1:0] o_step_m1
);

    localparam int          W_IDX   = $clog2(TABLE_SLOTS);
    localparam int          L_SH1   = $clog2(TABLE_SLOTS);
    localparam int          L_SH2   = $clog2(TABLE_SLOTS - 2);
    localparam logic [31:0] L_D1    = 32'(TABLE_SLOTS);
    localparam logic [31:0] L_D2    = 32'(TABLE_SLOTS - 2);
    localparam logic [63:0] L_M1    =
        ((64'd1 << (32 + L_SH1)) + 64'(L_D1) - 64'd1) / 64'(L_D1);
    localparam logic [63:0] L_M2    =
        ((64'd1 << (32 + L_SH2)) + 64'(L_D2) - 64'd1) / 64'(L_D2);
    localparam logic [31:0] L_M1_LO = L_M1[31:0];
    localparam logic [31:0] L_M2_LO = L_M2[31:0];

    logic [31:0]      r_key;
    logic [63:0]      r_p1;
    logic [63:0]      r_p2;
    logic [31:0]      r_q1;
    logic [31:0]      r_q2;
    logic [31:0]      r_qd1;
    logic [31:0]      r_qd2;
    logic [W_IDX-1:0] r_r1;
    logic [W_IDX-1:0] r_r2;
    logic [1:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [64:0]      w_full1;
    logic [64:0]      w_full2;

    // quotient by reciprocal: key * (2^32 + m_lo), then shift
    assign w_full1 = {1'b0, r_key, 32'd0} + {1'b0, r_p1};
    assign w_full2 = {1'b0, r_key, 32'd0} + {1'b0, r_p2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        r_p1  <= 64'(r_key) * 64'(L_M1_LO);
        r_p2  <= 64'(r_key) * 64'(L_M2_LO);
        r_q1  <= 32'(w_full1 >> (32 + L_SH1));
        r_q2  <= 32'(w_full2 >> (32 + L_SH2));
        r_qd1 <= r_q1 * L_D1;
        r_qd2 <= r_q2 * L_D2;
        r_r1  <= W_IDX'(r_key - r_qd1);
        r_r2  <= W_IDX'(r_key - r_qd2);
    end

    assign o_done    = r_done;
    assign o_first   = r_r1;
    assign o_step_m1 = r_r2;

endmodule

// File: rtl/dht_probe.sv
`timescale 1ns / 1ps
module dht_probe #(
    parameter int TABLE_SLOTS = dht_pkg::DEF_TABLE_SLOTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  dht_pkg::t_in                   i_in,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output dht_pkg::t_out                  o_res,
    output logic                           o_hash_start,
    output logic [31:0]                    o_hash_key,
    input  logic                           i_hash_done,
    input  logic [$clog2(TABLE_SLOTS)-1:0] i_hash_first,
    input  logic [$clog2(TABLE_SLOTS)-1:0] i_hash_step_m1
);

    localparam int W_IDX = $clog2(TABLE_SLOTS);
    localparam int W_CNT = $clog2(TABLE_SLOTS + 1);
    localparam logic [W_IDX:0]   L_S     = (W_IDX+1)'(TABLE_SLOTS);
    localparam logic [W_IDX-1:0] L_LAST  = W_IDX'(TABLE_SLOTS - 1);
    localparam logic [W_CNT-1:0] L_SLOTS = W_CNT'(TABLE_SLOTS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    dht_pkg::t_slot r_mem [TABLE_SLOTS];
    dht_pkg::t_slot r_rdata;

    logic [2:0]       r_state, n_state;
    logic [W_IDX-1:0] r_clr_idx, n_clr_idx;
    logic [W_CNT-1:0] r_count, n_count;
    logic [1:0]       r_cmd, n_cmd;
    logic [31:0]      r_key, n_key;
    logic [31:0]      r_val, n_val;
    logic [W_IDX-1:0] r_pos, n_pos;
    logic [W_IDX-1:0] r_step, n_step;
    logic [W_IDX-1:0] r_n, n_n;
    logic [2:0]       r_status, n_status;
    logic [31:0]      r_data, n_data;

    logic             w_we;
    logic [W_IDX-1:0] w_waddr;
    dht_pkg::t_slot   w_wdata;
    logic [W_IDX-1:0] w_raddr;
    logic [W_IDX:0]   w_sum;
    logic [W_IDX-1:0] w_next;
    logic             w_accept;

    always_comb begin
        w_sum = {1'b0, r_pos} + {1'b0, r_step};
        if (w_sum >= L_S) begin
            w_sum = w_sum - L_S;
        end
        w_next = w_sum[W_IDX-1:0];
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;
    assign o_hash_key   = i_in.key;
    assign o_hash_start = w_accept
                          && !((i_in.cmd == dht_pkg::CMD_INSERT) && (r_count >= L_SLOTS))
                          && !((i_in.cmd == dht_pkg::CMD_LOOKUP) && (r_count == '0))
                          && (i_in.cmd != dht_pkg::CMD_UNUSED);

    always_comb begin
        logic advance;
        logic hit;
        advance   = 1'b0;
        hit       = 1'b0;
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_count   = r_count;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_val     = r_val;
        n_pos     = r_pos;
        n_step    = r_step;
        n_n       = r_n;
        n_status  = r_status;
        n_data    = r_data;
        w_we      = 1'b0;
        w_waddr   = r_pos;
        w_wdata   = r_rdata;
        w_raddr   = r_pos;
        unique case (r_state)
            S_CLEAR: begin
                w_we      = 1'b1;
                w_waddr   = r_clr_idx;
                w_wdata   = '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == L_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd  = i_in.cmd;
                    n_key  = i_in.key;
                    n_val  = i_in.value;
                    n_data = '0;
                    if (o_hash_start) begin
                        n_state = S_HASH;
                    end else begin
                        n_status = (i_in.cmd == dht_pkg::CMD_INSERT) ?
                                   dht_pkg::ST_FULL : dht_pkg::ST_NOTFOUND;
                        n_state  = S_RESP;
                    end
                end
            end
            S_HASH: begin
                if (i_hash_done) begin
                    n_pos   = i_hash_first;
                    n_step  = i_hash_step_m1 + 1'b1;
                    n_n     = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                hit = (r_rdata.key == r_key);
                unique case (r_cmd)
                    dht_pkg::CMD_INSERT: begin
                        if (!r_rdata.active) begin
                            w_we     = 1'b1;
                            w_wdata  = '{active: 1'b1, key: r_key, value: r_val};
                            n_count  = r_count + 1'b1;
                            n_status = dht_pkg::ST_INSERTED;
                            n_state  = S_RESP;
                        end else if (hit) begin
                            w_we     = 1'b1;
                            w_wdata  = '{active: 1'b1, key: r_key, value: r_val};
                            n_status = dht_pkg::ST_UPDATED;
                            n_state  = S_RESP;
                        end else begin
                            advance = 1'b1;
                        end
                    end
                    dht_pkg::CMD_REMOVE: begin
                        if (r_rdata.value == '0) begin
                            n_status = dht_pkg::ST_NOTFOUND;
                            n_state  = S_RESP;
                        end else if (hit) begin
                            if (r_rdata.active) begin
                                w_we     = 1'b1;
                                w_wdata  = '{active: 1'b0, key: r_rdata.key,
                                             value: r_rdata.value};
                                n_count  = r_count - 1'b1;
                                n_data   = r_rdata.value;
                                n_status = dht_pkg::ST_REMOVED;
                            end else begin
                                n_status = dht_pkg::ST_NOTFOUND;
                            end
                            n_state = S_RESP;
                        end else begin
                            advance = 1'b1;
                        end
                    end
                    default: begin
                        if (hit) begin
                            if (r_rdata.active && (r_rdata.value != '0)) begin
                                n_data   = r_rdata.value;
                                n_status = dht_pkg::ST_FOUND;
                            end else begin
                                n_status = dht_pkg::ST_NOTFOUND;
                            end
                            n_state = S_RESP;
                        end else if (r_rdata.value == '0) begin
                            n_status = dht_pkg::ST_NOTFOUND;
                            n_state  = S_RESP;
                        end else begin
                            advance = 1'b1;
                        end
                    end
                endcase
                if (advance) begin
                    if (r_n == L_LAST) begin
                        n_status = (r_cmd == dht_pkg::CMD_INSERT) ?
                                   dht_pkg::ST_FULL : dht_pkg::ST_NOTFOUND;
                        n_state  = S_RESP;
                    end else begin
                        n_n     = r_n + 1'b1;
                        n_pos   = w_next;
                        w_raddr = w_next;
                    end
                end
            end
            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_val    <= n_val;
        r_pos    <= n_pos;
        r_step   <= n_step;
        r_n      <= n_n;
        r_status <= n_status;
        r_data   <= n_data;
    end

    assign o_res_valid        = (r_state == S_RESP);
    assign o_res.status       = r_status;
    assign o_res.result_value = r_data;
    assign o_res.entry_count  = 10'(r_count);

endmodule

// File: rtl/double_hash_table_engine_top.sv
`timescale 1ns / 1ps
// channel   dir  handshake                   payload
// in        in   i_in_valid / o_in_ready     i_in  (dht_pkg::t_in)
// out       out  o_out_valid / i_out_ready   o_out (dht_pkg::t_out)
//
// One operation at a time: an accept step, the hash (four multiply and
// reduce stages, then a done step), a read of the first probe slot, then
// one probe slot of the table memory per cycle, and a last step to hand the
// result to the output register.
// Insert on a full table, lookup on an empty one and the unused command skip
// the probe and go straight to the result hand-off. After reset the table is
// cleared one slot per cycle, slot by slot, before the first transfer is taken.
// The output register holds a result while a new operation runs; a stalled
// output holds the engine only once its next result is ready.
module double_hash_table_engine_top #(
    parameter int TABLE_SLOTS = dht_pkg::DEF_TABLE_SLOTS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dht_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output dht_pkg::t_out o_out
);

    localparam int W_IDX = $clog2(TABLE_SLOTS);

    logic             w_hash_start;
    logic [31:0]      w_hash_key;
    logic             w_hash_done;
    logic [W_IDX-1:0] w_hash_first;
    logic [W_IDX-1:0] w_hash_step_m1;
    logic             w_res_valid;
    logic             w_res_ready;
    dht_pkg::t_out    w_res;

    logic             r_out_valid;
    dht_pkg::t_out    r_out;

    dht_hash #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_hash (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_hash_start),
        .i_key     (w_hash_key),
        .o_done    (w_hash_done),
        .o_first   (w_hash_first),
        .o_step_m1 (w_hash_step_m1)
    );

    dht_probe #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_probe (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in           (i_in),
        .o_res_valid    (w_res_valid),
        .i_res_ready    (w_res_ready),
        .o_res          (w_res),
        .o_hash_start   (w_hash_start),
        .o_hash_key     (w_hash_key),
        .i_hash_done    (w_hash_done),
        .i_hash_first   (w_hash_first),
        .i_hash_step_m1 (w_hash_step_m1)
    );

    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: tb/double_hash_table_engine_top_tb.sv
`timescale 1ns / 1ps
module double_hash_table_engine_top_tb;

    localparam int          SLOTS       = dht_pkg::DEF_TABLE_SLOTS;
    localparam bit [31:0]   SLOTS_U     = SLOTS;
    localparam int          POOL_KEYS   = 48;
    localparam int          PHASE_ITEMS = 150;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    class hash_table_scoreboard;
        bit [31:0]     slot_key    [SLOTS];
        bit [31:0]     slot_value  [SLOTS];
        bit            slot_active [SLOTS];
        int unsigned   live_entries;
        dht_pkg::t_out expected_results [$];
        int unsigned   errors;

        function logic [2:0] table_insert(bit [31:0] k, bit [31:0] v);
            bit [31:0] pos;
            bit [31:0] stride;
            if (live_entries >= SLOTS) return dht_pkg::ST_FULL;
            pos    = k % SLOTS_U;
            stride = k % (SLOTS_U - 32'd2) + 32'd1;
            for (int n = 0; n < SLOTS; n++) begin
                if (slot_active[pos]) begin
                    if (slot_key[pos] == k) begin
                        slot_value[pos] = v;
                        return dht_pkg::ST_UPDATED;
                    end
                end else begin
                    slot_active[pos] = 1'b1;
                    slot_value[pos]  = v;
                    slot_key[pos]    = k;
                    live_entries++;
                    return dht_pkg::ST_INSERTED;
                end
                pos = (pos + stride) % SLOTS_U;
            end
            return dht_pkg::ST_FULL;
        endfunction

        function logic [2:0] table_remove(bit [31:0] k, output bit [31:0] data);
            bit [31:0] pos;
            bit [31:0] stride;
            data   = '0;
            pos    = k % SLOTS_U;
            stride = k % (SLOTS_U - 32'd2) + 32'd1;
            for (int n = 0; n < SLOTS; n++) begin
                if (slot_value[pos] == 32'd0) return dht_pkg::ST_NOTFOUND;
                if (slot_key[pos] == k) begin
                    if (!slot_active[pos]) return dht_pkg::ST_NOTFOUND;
                    slot_active[pos] = 1'b0;
                    live_entries--;
                    data = slot_value[pos];
                    return dht_pkg::ST_REMOVED;
                end
                pos = (pos + stride) % SLOTS_U;
            end
            return dht_pkg::ST_NOTFOUND;
        endfunction

        function logic [2:0] table_lookup(bit [31:0] k, output bit [31:0] data);
            bit [31:0] pos;
            bit [31:0] stride;
            data   = '0;
            pos    = k % SLOTS_U;
            stride = k % (SLOTS_U - 32'd2) + 32'd1;
            if (live_entries == 0) return dht_pkg::ST_NOTFOUND;
            for (int n = 0; n < SLOTS; n++) begin
                if (slot_key[pos] == k) begin
                    if (slot_active[pos] && slot_value[pos] != 32'd0) begin
                        data = slot_value[pos];
                        return dht_pkg::ST_FOUND;
                    end
                    return dht_pkg::ST_NOTFOUND;
                end
                if (slot_value[pos] == 32'd0) return dht_pkg::ST_NOTFOUND;
                pos = (pos + stride) % SLOTS_U;
            end
            return dht_pkg::ST_NOTFOUND;
        endfunction

        function void note_transfer(dht_pkg::t_in op);
            dht_pkg::t_out exp;
            bit [31:0]     data;
            data = '0;
            case (op.cmd)
                dht_pkg::CMD_INSERT: exp.status = table_insert(op.key, op.value);
                dht_pkg::CMD_REMOVE: exp.status = table_remove(op.key, data);
                dht_pkg::CMD_LOOKUP: exp.status = table_lookup(op.key, data);
                default:             exp.status = dht_pkg::ST_NOTFOUND;
            endcase
            exp.result_value = data;
            exp.entry_count  = 10'(live_entries);
            expected_results.push_back(exp);
        endfunction

        function void check_result(dht_pkg::t_out got);
            dht_pkg::t_out exp;
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d, result_value %h", got.status,
                       got.result_value);
                errors++;
                return;
            end
            exp = expected_results.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.result_value !== exp.result_value) begin
                $error("result_value: expected %h, got %h", exp.result_value,
                       got.result_value);
                errors++;
            end
            if (got.entry_count !== exp.entry_count) begin
                $error("entry_count: expected %0d, got %0d", exp.entry_count,
                       got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          o_in_ready;
    dht_pkg::t_in  i_in        = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    dht_pkg::t_out o_out;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;
    bit [31:0]   key_pool [POOL_KEYS];
    hash_table_scoreboard sb;

    double_hash_table_engine_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL double_hash_table_engine_top");
            $finish;
        end
    end

    function automatic dht_pkg::t_in make_op(logic [1:0] c, logic [31:0] k,
                                             logic [31:0] v);
        dht_pkg::t_in op;
        op.cmd   = c;
        op.key   = k;
        op.value = v;
        return op;
    endfunction

    function automatic dht_pkg::t_in random_op();
        int unsigned r;
        logic [1:0]  c;
        logic [31:0] k;
        logic [31:0] v;
        r = $urandom_range(99);
        if (r < 50)      c = dht_pkg::CMD_INSERT;
        else if (r < 70) c = dht_pkg::CMD_REMOVE;
        else if (r < 97) c = dht_pkg::CMD_LOOKUP;
        else             c = dht_pkg::CMD_UNUSED;
        k = ($urandom_range(99) < 80) ? key_pool[$urandom_range(POOL_KEYS - 1)] : $urandom;
        v = $urandom;
        if (v == 32'd0) v = 32'd1;
        return make_op(c, k, v);
    endfunction

    task automatic send_op(input dht_pkg::t_in op);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in       <= op;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_transfer(op);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        sb = new();
        for (int i = 0; i < POOL_KEYS; i++) begin
            // even entries share a handful of home slots to force long probes
            if (i % 2 == 0)
                key_pool[i] = $urandom_range(5) + 32'd1021 * $urandom_range(4_200_000);
            else
                key_pool[i] = $urandom;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_op(make_op(dht_pkg::CMD_LOOKUP, 32'd5, 32'd0));
        send_op(make_op(dht_pkg::CMD_UNUSED, 32'd5, 32'd9));
        // zero data word: stored, but reads as none
        send_op(make_op(dht_pkg::CMD_INSERT, 32'd7, 32'd0));
        send_op(make_op(dht_pkg::CMD_LOOKUP, 32'd7, 32'd0));
        send_op(make_op(dht_pkg::CMD_REMOVE, 32'd7, 32'd0));
        send_op(make_op(dht_pkg::CMD_INSERT, 32'd7, 32'hFFFF_FFFF));
        send_op(make_op(dht_pkg::CMD_LOOKUP, 32'd7, 32'd0));
        // two keys on one home slot, then shadow the second behind a tombstone
        send_op(make_op(dht_pkg::CMD_INSERT, 32'd5, 32'd1));
        send_op(make_op(dht_pkg::CMD_INSERT, 32'd1026, 32'd2));
        send_op(make_op(dht_pkg::CMD_REMOVE, 32'd5, 32'd0));
        send_op(make_op(dht_pkg::CMD_LOOKUP, 32'd5, 32'd0));
        send_op(make_op(dht_pkg::CMD_REMOVE, 32'd5, 32'd0));
        send_op(make_op(dht_pkg::CMD_INSERT, 32'd1026, 32'd3));
        send_op(make_op(dht_pkg::CMD_LOOKUP, 32'd1026, 32'd0));
        send_op(make_op(dht_pkg::CMD_REMOVE, 32'd1026, 32'd0));
        send_op(make_op(dht_pkg::CMD_LOOKUP, 32'd1026, 32'd0));
        send_op(make_op(dht_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h8000_0001));
        send_op(make_op(dht_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0));
        send_op(make_op(dht_pkg::CMD_INSERT, 32'd0, 32'h7FFF_FFFE));
        send_op(make_op(dht_pkg::CMD_LOOKUP, 32'd0, 32'd0));
        send_op(make_op(dht_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'd0));
        send_op(make_op(dht_pkg::CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_op(make_op(dht_pkg::CMD_LOOKUP, 32'd12345, 32'd0));
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 45;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 45;
                end
                default: begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                end
            endcase
            repeat (PHASE_ITEMS) send_op(random_op());
            drain_results();
        end
        repeat (64) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("PASS double_hash_table_engine_top");
        end else begin
            $display("FAIL double_hash_table_engine_top");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/dht_pkg.sv
rtl/dht_hash.sv
rtl/dht_probe.sv
rtl/double_hash_table_engine_top.sv
tb/double_hash_table_engine_top_tb.sv
